/* hdl/vbd_pkg.sv */
// shared types and constants for the voxel boundary detector
// no dependencies; imported by every module of the block except vbd_ram

package vbd_pkg;

  // input command codes, carried on s_tuser
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

  localparam int unsigned SIZE_W = 7;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

  // input tdata layout
  localparam int unsigned COORD_W    = 6;
  localparam int unsigned X_LSB      = 0;
  localparam int unsigned Y_LSB      = X_LSB + COORD_W;
  localparam int unsigned Z_LSB      = Y_LSB + COORD_W;
  localparam int unsigned SOLID_BIT  = Z_LSB + COORD_W;
  localparam int unsigned S_TDATA_W  = 24;
  localparam int unsigned M_TDATA_W  = 8;

  // neighbour offset along one axis
  typedef enum logic [1:0] {
    OFS_MINUS = 2'd0,
    OFS_ZERO  = 2'd1,
    OFS_PLUS  = 2'd2
  } ofs_t;

  typedef struct packed {
    ofs_t dx;
    ofs_t dy;
    ofs_t dz;
  } ofs3_t;

  localparam ofs3_t OFS3_FIRST  = '{dx: OFS_MINUS, dy: OFS_MINUS, dz: OFS_MINUS};
  localparam ofs3_t OFS3_CENTRE = '{dx: OFS_ZERO,  dy: OFS_ZERO,  dz: OFS_ZERO};
  localparam ofs3_t OFS3_LAST   = '{dx: OFS_PLUS,  dy: OFS_PLUS,  dz: OFS_PLUS};

  function automatic ofs_t ofs_next(input ofs_t o);
    ofs_t r;
    unique case (o)
      OFS_MINUS: r = OFS_ZERO;
      OFS_ZERO:  r = OFS_PLUS;
      default:   r = OFS_MINUS;
    endcase
    return r;
  endfunction

  // z runs fastest, then y, then x
  function automatic ofs3_t ofs3_next(input ofs3_t o);
    ofs3_t r;
    r = o;
    r.dz = ofs_next(o.dz);
    if (o.dz == OFS_PLUS) begin
      r.dy = ofs_next(o.dy);
      if (o.dy == OFS_PLUS) begin
        r.dx = ofs_next(o.dx);
      end
    end
    return r;
  endfunction

endpackage

/* hdl/vbd_ram.sv */
// generic single-port ram with registered read
// no dependencies

module vbd_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 262144
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* hdl/vbd_wrap.sv */
// periodic wrap step along one axis: coordinate plus -1, 0 or +1 modulo size
// depends on vbd_pkg

module vbd_wrap #(
  parameter int unsigned MAX_N = 64
) (
  input  logic [$clog2(MAX_N)-1:0]   coord,
  input  logic [$clog2(MAX_N+1)-1:0] size,
  input  vbd_pkg::ofs_t              ofs,
  output logic [$clog2(MAX_N)-1:0]   step
);

  import vbd_pkg::*;

  localparam int unsigned CW = $clog2(MAX_N);
  localparam int unsigned SW = $clog2(MAX_N+1);

  logic [SW-1:0] c_ext;
  logic [SW-1:0] c_inc;
  logic [SW-1:0] c_dec;

  always_comb begin
    c_ext = SW'(coord);
    c_inc = c_ext + SW'(1);
    c_dec = (c_ext == '0) ? size - SW'(1) : c_ext - SW'(1);
    unique case (ofs)
      OFS_MINUS: step = CW'(c_dec);
      OFS_PLUS:  step = (c_inc == size) ? '0 : CW'(c_inc);
      default:   step = coord;
    endcase
  end

endmodule

/* hdl/vbd_seq.sv */
// sequencer: takes items, writes cells, walks the 27 neighbours of a query
// through one read port and holds the result register; depends on vbd_pkg, vbd_wrap

module vbd_seq #(
  parameter int unsigned MAX_X = 64,
  parameter int unsigned MAX_Y = 64,
  parameter int unsigned MAX_Z = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [$clog2(MAX_X+1)-1:0]        eff_x,
  input  logic [$clog2(MAX_Y+1)-1:0]        eff_y,
  input  logic [$clog2(MAX_Z+1)-1:0]        eff_z,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [vbd_pkg::S_TDATA_W-1:0]     s_tdata,
  input  logic                              s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [vbd_pkg::M_TDATA_W-1:0]     m_tdata,
  output logic                              m_tuser,
  output logic                              ram_we,
  output logic [$clog2(MAX_X)+$clog2(MAX_Y)+$clog2(MAX_Z)-1:0] ram_addr,
  output logic                              ram_wdata,
  input  logic                              ram_rdata
);

  import vbd_pkg::*;

  localparam int unsigned XW = $clog2(MAX_X);
  localparam int unsigned YW = $clog2(MAX_Y);
  localparam int unsigned ZW = $clog2(MAX_Z);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_HOLD} state_t;

  state_t        state;
  logic [XW-1:0] crd_x;
  logic [YW-1:0] crd_y;
  logic [ZW-1:0] crd_z;
  ofs3_t         ofs;
  logic          rd_pend;
  logic          rd_centre;
  logic          hit;
  logic          centre;
  logic          res_boundary;
  logic          res_bad;

  logic [COORD_W-1:0] in_x;
  logic [COORD_W-1:0] in_y;
  logic [COORD_W-1:0] in_z;
  logic               in_solid;
  logic               in_bad;
  logic               accept;
  logic [XW-1:0]      nb_x;
  logic [YW-1:0]      nb_y;
  logic [ZW-1:0]      nb_z;

  assign in_x     = s_tdata[X_LSB +: COORD_W];
  assign in_y     = s_tdata[Y_LSB +: COORD_W];
  assign in_z     = s_tdata[Z_LSB +: COORD_W];
  assign in_solid = s_tdata[SOLID_BIT];
  assign in_bad   = (32'(in_x) >= 32'(eff_x)) || (32'(in_y) >= 32'(eff_y)) ||
                    (32'(in_z) >= 32'(eff_z));

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  vbd_wrap #(.MAX_N(MAX_X)) u_wrap_x (.coord(crd_x), .size(eff_x), .ofs(ofs.dx), .step(nb_x));
  vbd_wrap #(.MAX_N(MAX_Y)) u_wrap_y (.coord(crd_y), .size(eff_y), .ofs(ofs.dy), .step(nb_y));
  vbd_wrap #(.MAX_N(MAX_Z)) u_wrap_z (.coord(crd_z), .size(eff_z), .ofs(ofs.dz), .step(nb_z));

  // the port serves the write of an incoming item while idle, the neighbour walk otherwise
  always_comb begin
    ram_we    = accept && (s_tuser == CMD_WRITE) && !in_bad;
    ram_wdata = in_solid;
    if (state == S_IDLE) begin
      ram_addr = {XW'(in_x), YW'(in_y), ZW'(in_z)};
    end else begin
      ram_addr = {nb_x, nb_y, nb_z};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      rd_pend  <= 1'b0;
    end else begin
      rd_pend <= (state == S_SCAN);
      if ((state == S_HOLD) && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && (s_tuser == CMD_QUERY)) begin
            crd_x        <= XW'(in_x);
            crd_y        <= YW'(in_y);
            crd_z        <= ZW'(in_z);
            ofs          <= OFS3_FIRST;
            hit          <= 1'b0;
            centre       <= 1'b0;
            res_boundary <= 1'b0;
            res_bad      <= in_bad;
            state        <= in_bad ? S_HOLD : S_SCAN;
          end
        end
        S_SCAN: begin
          rd_centre <= (ofs == OFS3_CENTRE);
          ofs       <= ofs3_next(ofs);
          if (ofs == OFS3_LAST) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          // last neighbour is never the centre, so centre is settled here
          res_boundary <= !centre && (hit || ram_rdata);
          state        <= S_HOLD;
        end
        S_HOLD: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= M_TDATA_W'(res_boundary);
            m_tuser  <= res_bad;
            state    <= S_IDLE;
          end
        end
      endcase
      if (rd_pend) begin
        hit <= hit || ram_rdata;
        if (rd_centre) begin
          centre <= ram_rdata;
        end
      end
    end
  end

endmodule

/* hdl/voxel_boundary_detect_3d_unit.sv */
// top level of the voxel boundary detector: size registers, sequencer, cell store
// depends on vbd_pkg, vbd_seq, vbd_ram
//
//  channel | direction | tdata / payload                    | tuser
//  s_*     | in        | cell_x, cell_y, cell_z, solid      | command
//  m_*     | out       | boundary                           | bad_coordinate
//  cfg_*   | in        | cfg_index, cfg_data (size_x/y/z)   | -
//
// a write leaves the block ready in the next cycle; a query in range reads its 27
// neighbours from the single-port cell store at one read a cycle, takes the last read
// in the drain state and loads the output in the hold state, which offers the result
// and makes the input ready again; a query out of range goes straight to the hold state
// rst is synchronous; sizes return to 64, the cell store is not cleared
// a result held by m_tready low lets one more query run, whose result then waits
// in the sequencer and keeps the block from taking anything until the held one leaves

module voxel_boundary_detect_3d_unit #(
  parameter int unsigned MAX_X = 64,
  parameter int unsigned MAX_Y = 64,
  parameter int unsigned MAX_Z = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [vbd_pkg::S_TDATA_W-1:0] s_tdata,   // cell_x, cell_y, cell_z, solid, zero pad
  input  logic                          s_tuser,   // command
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [vbd_pkg::M_TDATA_W-1:0] m_tdata,   // boundary, zero pad
  output logic                          m_tuser,   // bad_coordinate
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [vbd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vbd_pkg::SIZE_W-1:0]    cfg_data
);

  import vbd_pkg::*;

  localparam int unsigned XSW = $clog2(MAX_X+1);
  localparam int unsigned YSW = $clog2(MAX_Y+1);
  localparam int unsigned ZSW = $clog2(MAX_Z+1);
  localparam int unsigned AW  = $clog2(MAX_X) + $clog2(MAX_Y) + $clog2(MAX_Z);

  logic [SIZE_W-1:0] size_x;
  logic [SIZE_W-1:0] size_y;
  logic [SIZE_W-1:0] size_z;
  logic [XSW-1:0]    eff_x;
  logic [YSW-1:0]    eff_y;
  logic [ZSW-1:0]    eff_z;
  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic              ram_wdata;
  logic              ram_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x <= SIZE_RESET;
      size_y <= SIZE_RESET;
      size_z <= SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SIZE_X: size_x <= cfg_data;
        REG_SIZE_Y: size_y <= cfg_data;
        REG_SIZE_Z: size_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // sizes beyond the store extent clamp to it
  always_comb begin
    eff_x = (32'(size_x) > 32'(MAX_X)) ? XSW'(MAX_X) : XSW'(size_x);
    eff_y = (32'(size_y) > 32'(MAX_Y)) ? YSW'(MAX_Y) : YSW'(size_y);
    eff_z = (32'(size_z) > 32'(MAX_Z)) ? ZSW'(MAX_Z) : ZSW'(size_z);
  end

  vbd_seq #(
    .MAX_X(MAX_X),
    .MAX_Y(MAX_Y),
    .MAX_Z(MAX_Z)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .eff_x    (eff_x),
    .eff_y    (eff_y),
    .eff_z    (eff_z),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .ram_we   (ram_we),
    .ram_addr (ram_addr),
    .ram_wdata(ram_wdata),
    .ram_rdata(ram_rdata)
  );

  vbd_ram #(
    .WIDTH(1),
    .DEPTH(2 ** AW)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

endmodule

/* hdl/vbd_checker.sv */
// port-level checks for the voxel boundary detector, bound to the top level
// depends on vbd_pkg and voxel_boundary_detect_3d_unit

module vbd_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          s_tuser,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [vbd_pkg::M_TDATA_W-1:0] m_tdata,
  input logic                          m_tuser
);

  import vbd_pkg::*;

  // a query keeps the block busy for at least the next cycle
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == CMD_QUERY) |=> !s_tready)
    else $error("block ready straight after a query transaction");

  // a write leaves the block ready again in the next cycle
  a_write_one_cycle: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == CMD_WRITE) |=> s_tready)
    else $error("block busy after a write transaction");

  // an out-of-range query never reports a boundary
  a_bad_no_boundary: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> !m_tdata[0])
    else $error("boundary set together with bad coordinate");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result dropped or changed while stalled");

endmodule

bind voxel_boundary_detect_3d_unit vbd_checker u_vbd_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .s_tuser (s_tuser),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser)
);

/* bench/voxel_boundary_detect_3d_unit_tb.sv */
// self-checking bench for voxel_boundary_detect_3d_unit: cell writes and boundary queries
// checked against an in-bench predictor; depends on vbd_pkg and the unit under test

module voxel_boundary_detect_3d_unit_tb;
  import vbd_pkg::*;

  localparam int unsigned GRID          = 64;
  localparam int unsigned CELL_COUNT    = GRID * GRID * GRID;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned QUIET_LIMIT   = 3000;
  localparam int unsigned REPORT_LIMIT  = 10;

  typedef struct packed {
    logic boundary;
    logic bad_coordinate;
  } probe_result_t;

  // predictor: mirrors the cell store and size registers, queues one result per query
  class boundary_scoreboard;
    bit                solid_cells [CELL_COUNT];
    logic [SIZE_W-1:0] size_reg [3];
    probe_result_t     expected_q [$];
    int unsigned       mismatches;

    function new();
      foreach (size_reg[i]) size_reg[i] = SIZE_RESET;
      mismatches = 0;
    endfunction

    function int unsigned extent(logic [CFG_IDX_W-1:0] axis);
      return (size_reg[axis] > GRID) ? GRID : size_reg[axis];
    endfunction

    function int unsigned cell_addr(int unsigned x, int unsigned y, int unsigned z);
      return (x * GRID + y) * GRID + z;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] data);
      case (idx)
        REG_SIZE_X, REG_SIZE_Y, REG_SIZE_Z: begin
          size_reg[idx] = data;
        end
        default: begin
        end
      endcase
    endfunction

    function void note_input(logic cmd, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                             logic [COORD_W-1:0] z, logic solid);
      int unsigned   nx, ny, nz;
      bit            bad, hit;
      probe_result_t r;
      nx  = extent(REG_SIZE_X);
      ny  = extent(REG_SIZE_Y);
      nz  = extent(REG_SIZE_Z);
      bad = (x >= nx) || (y >= ny) || (z >= nz);
      if (cmd == CMD_WRITE) begin
        if (!bad) solid_cells[cell_addr(x, y, z)] = solid;
        return;
      end
      hit = 1'b0;
      if (!bad && !solid_cells[cell_addr(x, y, z)]) begin
        // neighbourhood wraps periodically at the sizes in use
        for (int dx = 0; dx < 3; dx++)
          for (int dy = 0; dy < 3; dy++)
            for (int dz = 0; dz < 3; dz++)
              if (solid_cells[cell_addr((x + nx + dx - 1) % nx, (y + ny + dy - 1) % ny,
                                        (z + nz + dz - 1) % nz)])
                hit = 1'b1;
      end
      r.boundary       = hit;
      r.bad_coordinate = bad;
      expected_q.push_back(r);
    endfunction

    function void check_result(logic boundary, logic bad);
      probe_result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("result with nothing pending: boundary %0b bad_coordinate %0b",
                   boundary, bad);
        return;
      end
      want = expected_q.pop_front();
      if (want.boundary !== boundary || want.bad_coordinate !== bad) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("mismatch: boundary exp %0b got %0b, bad_coordinate exp %0b got %0b",
                   want.boundary, boundary, want.bad_coordinate, bad);
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;
  logic                 s_tuser;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tuser;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SIZE_W-1:0]    cfg_data;

  voxel_boundary_detect_3d_unit uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  boundary_scoreboard sb;
  bit                 primed [CELL_COUNT];  // cells the stimulus has written in range
  int unsigned        items_sent;
  int unsigned        burst_left;
  int unsigned        solid_pct;
  int unsigned        cx, cy, cz;
  int unsigned        quiet_cycles;
  logic [15:0]        ready_pattern;
  int unsigned        ready_age;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic coin_solid();
    return $urandom_range(0, 99) < solid_pct;
  endfunction

  function automatic int unsigned near(int unsigned c, int unsigned n);
    return (c + $urandom_range(0, 4)) % n;
  endfunction

  task automatic send_cell(logic cmd, int unsigned x, int unsigned y, int unsigned z,
                           logic solid);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        s_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_tdata                    = '0;
    s_tdata[X_LSB +: COORD_W]  = COORD_W'(x);
    s_tdata[Y_LSB +: COORD_W]  = COORD_W'(y);
    s_tdata[Z_LSB +: COORD_W]  = COORD_W'(z);
    s_tdata[SOLID_BIT]         = solid;
    s_tuser                    = cmd;
    s_tvalid                   = 1'b1;
    do @(posedge clk); while (!s_tready);
    sb.note_input(cmd, COORD_W'(x), COORD_W'(y), COORD_W'(z), solid);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic put_cell(int unsigned x, int unsigned y, int unsigned z, logic solid);
    if (x < sb.extent(REG_SIZE_X) && y < sb.extent(REG_SIZE_Y) && z < sb.extent(REG_SIZE_Z))
      primed[sb.cell_addr(x, y, z)] = 1'b1;
    send_cell(CMD_WRITE, x, y, z, solid);
  endtask

  // fills any unwritten neighbour first so the query never touches an undefined cell
  task automatic ask_cell(int unsigned x, int unsigned y, int unsigned z);
    int unsigned nx, ny, nz, wx, wy, wz;
    nx = sb.extent(REG_SIZE_X);
    ny = sb.extent(REG_SIZE_Y);
    nz = sb.extent(REG_SIZE_Z);
    if (x < nx && y < ny && z < nz) begin
      for (int dx = 0; dx < 3; dx++)
        for (int dy = 0; dy < 3; dy++)
          for (int dz = 0; dz < 3; dz++) begin
            wx = (x + nx + dx - 1) % nx;
            wy = (y + ny + dy - 1) % ny;
            wz = (z + nz + dz - 1) % nz;
            if (!primed[sb.cell_addr(wx, wy, wz)]) put_cell(wx, wy, wz, coin_solid());
          end
    end
    send_cell(CMD_QUERY, x, y, z, 1'($urandom_range(0, 1)));
  endtask

  // write or query with at least one coordinate at or beyond its size
  task automatic stray_item();
    int unsigned          c [3];
    logic [CFG_IDX_W-1:0] a;
    foreach (c[i]) c[i] = $urandom_range(0, GRID - 1);
    do a = CFG_IDX_W'($urandom_range(0, 2)); while (sb.extent(a) >= GRID);
    c[a] = $urandom_range(sb.extent(a), GRID - 1);
    send_cell(1'($urandom_range(0, 1)), c[REG_SIZE_X], c[REG_SIZE_Y], c[REG_SIZE_Z],
              1'($urandom_range(0, 1)));
  endtask

  task automatic wait_idle();
    s_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] data);
    cfg_index = idx;
    cfg_data  = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.note_config(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic configure(logic [SIZE_W-1:0] sx, logic [SIZE_W-1:0] sy,
                           logic [SIZE_W-1:0] sz);
    wait_idle();
    write_reg(REG_SIZE_X, sx);
    write_reg(REG_SPARE, SIZE_W'($urandom_range(0, 127)));
    write_reg(REG_SIZE_Y, sy);
    write_reg(REG_SIZE_Z, sz);
    burst_left = 0;
  endtask

  task automatic run_phase(int unsigned count, int unsigned pct);
    int unsigned stop_at, nx, ny, nz, r;
    bit          any_empty, any_room;
    solid_pct = pct;
    stop_at   = items_sent + count;
    nx        = sb.extent(REG_SIZE_X);
    ny        = sb.extent(REG_SIZE_Y);
    nz        = sb.extent(REG_SIZE_Z);
    any_empty = (nx == 0) || (ny == 0) || (nz == 0);
    any_room  = (nx < GRID) || (ny < GRID) || (nz < GRID);
    if (!any_empty) begin
      cx = $urandom_range(0, nx - 1);
      cy = $urandom_range(0, ny - 1);
      cz = $urandom_range(0, nz - 1);
    end
    while (items_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (any_empty || (any_room && r < 12)) begin
        stray_item();
      end else begin
        // hop the working cluster now and then so the store fills in patches
        if (r >= 95) begin
          cx = $urandom_range(0, nx - 1);
          cy = $urandom_range(0, ny - 1);
          cz = $urandom_range(0, nz - 1);
        end
        if (r < 45) put_cell(near(cx, nx), near(cy, ny), near(cz, nz), coin_solid());
        else ask_cell(near(cx, nx), near(cy, ny), near(cz, nz));
      end
    end
  endtask

  // receiver back-pressure from a rotating pattern, reloaded whenever ready_age wraps to zero
  always @(negedge clk) begin
    if (ready_age == 0) begin
      case ($urandom_range(0, 2))
        0:       ready_pattern = '1;
        1:       ready_pattern = 16'($urandom()) | 16'h0001;
        default: ready_pattern = 16'($urandom() & $urandom()) | 16'h0001;
      endcase
    end
    m_tready      = ready_pattern[0];
    ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
    ready_age     = (ready_age + 1) % 64;
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata[0], m_tuser);
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = CMD_WRITE;
    cfg_valid    = 1'b0;
    cfg_index    = REG_SIZE_X;
    cfg_data     = '0;
    items_sent   = 0;
    burst_left   = 0;
    solid_pct    = 30;
    sb           = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: 2x2x2 grid, wrap onto the far cell, solid centre, ignored writes
    configure(7'd2, 7'd2, 7'd2);
    for (int x = 0; x < 2; x++)
      for (int y = 0; y < 2; y++)
        for (int z = 0; z < 2; z++)
          put_cell(x, y, z, (x == 1) && (y == 1) && (z == 1));
    ask_cell(0, 0, 0);
    ask_cell(1, 1, 1);
    put_cell(1, 1, 1, 1'b0);
    ask_cell(0, 0, 0);
    put_cell(63, 63, 63, 1'b1);
    put_cell(2, 0, 0, 1'b1);
    ask_cell(0, 0, 0);
    ask_cell(63, 0, 0);
    ask_cell(0, 63, 0);
    ask_cell(0, 0, 63);
    ask_cell(63, 63, 63);

    // full extent, queries at both corners wrap across every edge
    configure(7'd64, 7'd64, 7'd64);
    solid_pct = 20;
    ask_cell(0, 0, 0);
    ask_cell(63, 63, 63);
    run_phase(190, 20);

    configure(7'd4, 7'd4, 7'd4);
    run_phase(200, 30);
    configure(7'd1, 7'd1, 7'd1);
    run_phase(60, 50);
    configure(7'd1, 7'd64, 7'd3);
    run_phase(150, 25);
    configure(7'd0, 7'd7, 7'd7);
    run_phase(50, 30);
    // sizes past the store extent act as the maximum
    configure(7'd127, 7'd65, 7'd2);
    run_phase(200, 10);
    configure(7'd5, 7'd1, 7'd64);
    run_phase(150, 40);
    for (int p = 0; p < 3; p++) begin
      configure(SIZE_W'($urandom_range(1, 64)), SIZE_W'($urandom_range(1, 64)),
                SIZE_W'($urandom_range(1, 64)));
      run_phase(150, $urandom_range(2, 60));
    end

    wait_idle();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
